FILE: rtl/gbba_pkg.sv
// gbba_pkg: shared types and constants of the group bitmap block allocator.
// Used by the allocator unit and gbba_checker under rtl/; depends on nothing.
`timescale 1ns / 1ps

package gbba_pkg;

  // Sizing
  localparam int MAX_GROUPS           = 16;
  localparam int MAX_BLOCKS_PER_GROUP = 8192;
  localparam int WORDS_PER_GROUP      = (MAX_BLOCKS_PER_GROUP + 31) / 32;
  localparam int BITMAP_DEPTH         = MAX_GROUPS * WORDS_PER_GROUP;
  localparam int GROUP_W              = 4;
  localparam int WIDX_W               = 8;
  localparam int BITMAP_AW            = GROUP_W + WIDX_W;
  localparam int FREE_W               = 14;
  localparam logic [FREE_W-1:0] GROUP_FREE_MAX = 14'd16383;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_GROUP = 2'd1;

  // Opcodes
  localparam logic [1:0] OP_LOAD_WORD  = 2'd0;
  localparam logic [1:0] OP_GROUP_FREE = 2'd1;
  localparam logic [1:0] OP_TOTAL_FREE = 2'd2;
  localparam logic [1:0] OP_ALLOCATE   = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [GROUP_W-1:0] group_sel;
    logic [WIDX_W-1:0] word_index;
    logic [31:0]       load_value;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [16:0] block_number;
    logic [31:0] total_free_left;
  } out_item_t;

endpackage

FILE: rtl/gbba_bitmap_ram.sv
// gbba_bitmap_ram: single-port-write, single-port-read synchronous RAM
// holding the allocation bitmaps; read data is registered. No dependencies.
`timescale 1ns / 1ps

module gbba_bitmap_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/group_bitmap_block_allocator_unit.sv
// group_bitmap_block_allocator_unit: allocate sequencer around the bitmap RAM.
// Depends on gbba_pkg and gbba_bitmap_ram.
`timescale 1ns / 1ps
// A load item leaves the sequencer idle and gives no result. An allocate item
//   starts at the last successful group, reduces it below the group count (ST_MOD),
//   visits groups (ST_GRP) and reads then checks each bitmap word (ST_RD, ST_CHK)
//   until a hit; a refused one passes ST_FAIL, straight from ST_MOD with a zero
//   group count or block limit. One item at a time; input stalls until the result
//   is registered from ST_OUT, also while it waits behind a stalled output. Reset:
//   control, group free counts, total and last group clear; bitmap RAM undefined.

module group_bitmap_block_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gbba_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gbba_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbba_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MOD  = 7'b0000010,
    ST_GRP  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_FAIL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  group_count_r;
  logic [13:0] blocks_in_group_r;
  logic [31:0] total_r, total_nxt;
  logic [gbba_pkg::GROUP_W-1:0] last_r, last_nxt;
  logic [gbba_pkg::FREE_W-1:0]  gf_r [gbba_pkg::MAX_GROUPS];

  logic [4:0]  g_r, g_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [gbba_pkg::WIDX_W-1:0] w_r, w_nxt;
  logic [17:0] base_r, base_nxt;
  gbba_pkg::out_item_t res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  gbba_pkg::out_item_t out_r, out_nxt;

  logic        gf_we;
  logic [gbba_pkg::GROUP_W-1:0] gf_idx;
  logic [gbba_pkg::FREE_W-1:0]  gf_wdata;

  logic        ram_we, ram_re;
  logic [gbba_pkg::BITMAP_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic        in_acc;
  logic [4:0]  count_w;
  logic [13:0] bpg_w;
  logic [8:0]  nwords_w;
  logic        last_word_w;
  logic [31:0] pad_w, masked_w;
  logic [5:0]  hit_w;
  logic [4:0]  g_adv_w;
  logic [12:0] j_w;

  // lowest clear bit: {found, index}
  function automatic logic [5:0] lowest_zero(input logic [31:0] w);
    logic [5:0] r;
    r = 6'd0;
    for (int k = 31; k >= 0; k--) begin
      if (!w[k]) r = {1'b1, 5'(k)};
    end
    return r;
  endfunction

  gbba_bitmap_ram #(
    .DEPTH (gbba_pkg::BITMAP_DEPTH),
    .WIDTH (32),
    .ADDR_W(gbba_pkg::BITMAP_AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // clamped configuration and word limits
  assign count_w  = (group_count_r > 5'(gbba_pkg::MAX_GROUPS)) ?
                    5'(gbba_pkg::MAX_GROUPS) : group_count_r;
  assign bpg_w    = (blocks_in_group_r > 14'(gbba_pkg::MAX_BLOCKS_PER_GROUP)) ?
                    14'(gbba_pkg::MAX_BLOCKS_PER_GROUP) : blocks_in_group_r;
  assign nwords_w = 9'((15'(bpg_w) + 15'd31) >> 5);
  assign last_word_w = ({1'b0, w_r} == (nwords_w - 9'd1));
  assign pad_w    = (last_word_w && (bpg_w[4:0] != 5'd0)) ?
                    ~((32'd1 << bpg_w[4:0]) - 32'd1) : 32'd0;
  assign masked_w = ram_rdata | pad_w;
  assign hit_w    = lowest_zero(masked_w);
  assign g_adv_w  = ((g_r + 5'd1) == count_w) ? 5'd0 : (g_r + 5'd1);
  assign j_w      = {w_r, hit_w[4:0]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r     <= 5'd1;
      blocks_in_group_r <= 14'd8192;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbba_pkg::CFG_GROUP_COUNT:     group_count_r     <= cfg_data[4:0];
        gbba_pkg::CFG_BLOCKS_IN_GROUP: blocks_in_group_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    g_nxt         = g_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    gf_we         = 1'b0;
    gf_idx        = g_r[gbba_pkg::GROUP_W-1:0];
    gf_wdata      = gf_r[g_r[gbba_pkg::GROUP_W-1:0]] - 14'd1;
    ram_we        = 1'b0;
    ram_waddr     = {g_r[gbba_pkg::GROUP_W-1:0], w_r};
    ram_wdata     = ram_rdata | (32'd1 << hit_w[4:0]);
    ram_re        = 1'b0;
    ram_raddr     = {g_r[gbba_pkg::GROUP_W-1:0], w_r};

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            gbba_pkg::OP_LOAD_WORD: begin
              ram_we    = 1'b1;
              ram_waddr = {in_data.group_sel, in_data.word_index};
              ram_wdata = in_data.load_value;
            end
            gbba_pkg::OP_GROUP_FREE: begin
              gf_we    = 1'b1;
              gf_idx   = in_data.group_sel;
              gf_wdata = (in_data.load_value > 32'(gbba_pkg::GROUP_FREE_MAX)) ?
                         gbba_pkg::GROUP_FREE_MAX : in_data.load_value[13:0];
            end
            gbba_pkg::OP_TOTAL_FREE: total_nxt = in_data.load_value;
            default: begin
              g_nxt     = {1'b0, last_r};
              i_nxt     = 5'd0;
              state_nxt = ST_MOD;
            end
          endcase
        end
      end
      // reduce the start group below the group count
      ST_MOD: begin
        if (count_w == 5'd0 || bpg_w == 14'd0) begin
          state_nxt = ST_FAIL;
        end else if (g_r >= count_w) begin
          g_nxt = g_r - count_w;
        end else begin
          state_nxt = ST_GRP;
        end
      end
      // pick next group with free blocks
      ST_GRP: begin
        if (i_r == count_w) begin
          state_nxt = ST_FAIL;
        end else if (gf_r[g_r[gbba_pkg::GROUP_W-1:0]] == '0) begin
          g_nxt = g_adv_w;
          i_nxt = i_r + 5'd1;
        end else begin
          w_nxt     = '0;
          base_nxt  = 18'(g_r[gbba_pkg::GROUP_W-1:0]) * 18'(bpg_w);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_CHK;
      end
      // check the word; on a hit set the bit and update the counts
      ST_CHK: begin
        if (hit_w[5]) begin
          ram_we    = 1'b1;
          gf_we     = 1'b1;
          if (total_r != 32'd0) total_nxt = total_r - 32'd1;
          last_nxt  = g_r[gbba_pkg::GROUP_W-1:0];
          res_nxt.granted         = 1'b1;
          res_nxt.block_number    = 17'(base_r + 18'(j_w));
          res_nxt.total_free_left = (total_r != 32'd0) ? (total_r - 32'd1) : 32'd0;
          state_nxt = ST_OUT;
        end else if (last_word_w) begin
          g_nxt     = g_adv_w;
          i_nxt     = i_r + 5'd1;
          state_nxt = ST_GRP;
        end else begin
          w_nxt     = w_r + 8'd1;
          state_nxt = ST_RD;
        end
      end
      ST_FAIL: begin
        res_nxt.granted         = 1'b0;
        res_nxt.block_number    = '0;
        res_nxt.total_free_left = total_r;
        state_nxt = ST_OUT;
      end
      // hand the result to the output register when it is free
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < gbba_pkg::MAX_GROUPS; k++) gf_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (gf_we) gf_r[gf_idx] <= gf_wdata;
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    g_r    <= g_nxt;
    i_r    <= i_nxt;
    w_r    <= w_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: rtl/gbba_checker.sv
// gbba_checker: port-level assertions for group_bitmap_block_allocator_unit,
// bound to the top level below. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gbba_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gbba_pkg::out_item_t out_data
);

  // no result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a refused allocation carries block number zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.granted) |-> (out_data.block_number == 17'd0))
    else $error("failed allocation with nonzero block number");

  // an allocate item occupies the sequencer
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == gbba_pkg::OP_ALLOCATE) |=> in_stall)
    else $error("input not stalled after allocate item");

  // load items leave the sequencer idle, so the input is not stalled after them
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode != gbba_pkg::OP_ALLOCATE) |=> !in_stall)
    else $error("input stalled after load item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind group_bitmap_block_allocator_unit gbba_checker u_gbba_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

FILE: test/gbba_alloc_checker.sv
// gbba_alloc_checker: watches the item, result and configuration channels of the
// group bitmap block allocator, predicts every allocate result and compares it.
// Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_alloc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  gbba_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  gbba_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbba_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              outstanding
);
  import gbba_pkg::*;

  // Shadow copy of the allocator state
  logic [31:0]        bitmap_img [MAX_GROUPS][WORDS_PER_GROUP];
  logic [FREE_W-1:0]  free_img [MAX_GROUPS];
  logic [31:0]        total_img;
  logic [GROUP_W-1:0] last_img;
  logic [4:0]         group_count_reg;
  logic [13:0]        blocks_per_group_reg;

  out_item_t grant_queue[$];
  int        fail_count;

  initial begin
    fail_count  = 0;
    failures    = 0;
    outstanding = 0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      free_img[g] = '0;
      for (int w = 0; w < WORDS_PER_GROUP; w++) bitmap_img[g][w] = '0;
    end
    total_img            = '0;
    last_img             = '0;
    group_count_reg      = 5'd1;
    blocks_per_group_reg = 14'd8192;
  end

  // Lowest clear bit of group g below limit, -1 when the group is full
  function automatic int lowest_clear(int g, int limit);
    logic [31:0] word;
    int w;
    int b;
    for (w = 0; w * 32 < limit; w++) begin
      word = bitmap_img[g][w];
      // bits at or above the limit count as used
      if (limit - w * 32 < 32) word = word | ~((32'd1 << (limit - w * 32)) - 32'd1);
      if (word != 32'hFFFF_FFFF) begin
        for (b = 0; b < 32; b++) begin
          if (!word[b]) return w * 32 + b;
        end
      end
    end
    return -1;
  endfunction

  // Round-robin scan from the last successful group; updates the shadow state
  function automatic out_item_t allocate_block();
    out_item_t res;
    int count;
    int bpg;
    int i;
    int g;
    int j;
    res   = '0;
    count = (group_count_reg > MAX_GROUPS) ? MAX_GROUPS : int'(group_count_reg);
    bpg   = (blocks_per_group_reg > MAX_BLOCKS_PER_GROUP) ? MAX_BLOCKS_PER_GROUP
                                                        : int'(blocks_per_group_reg);
    for (i = 0; i < count && !res.granted; i++) begin
      g = (int'(last_img) % count + i) % count;
      if (free_img[g] != '0) begin
        j = lowest_clear(g, bpg);
        if (j >= 0) begin
          bitmap_img[g][j / 32][j % 32] = 1'b1;
          free_img[g] = free_img[g] - FREE_W'(1);
          if (total_img != '0) total_img = total_img - 32'd1;
          last_img           = GROUP_W'(g);
          res.granted        = 1'b1;
          res.block_number   = 17'(g * bpg + j);
        end
      end
    end
    res.total_free_left = total_img;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_res;
    logic      bad;
    if (!rst_n) begin
      for (int g = 0; g < MAX_GROUPS; g++) free_img[g] = '0;
      total_img            = '0;
      last_img             = '0;
      group_count_reg      = 5'd1;
      blocks_per_group_reg = 14'd8192;
      grant_queue.delete();
    end else begin
      // Result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (grant_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result granted=%0d block=%0d total=%0d", $time,
                   out_data.granted, out_data.block_number, out_data.total_free_left);
        end else begin
          exp_res = grant_queue.pop_front();
          bad = (out_data.granted !== exp_res.granted) ||
                (out_data.block_number !== exp_res.block_number) ||
                (out_data.total_free_left !== exp_res.total_free_left);
          if (bad) begin
            fail_count++;
            $display("%0t: expected g=%0d b=%0d t=%0d, got g=%0d b=%0d t=%0d",
                     $time, exp_res.granted, exp_res.block_number, exp_res.total_free_left,
                     out_data.granted, out_data.block_number, out_data.total_free_left);
          end
        end
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GROUP_COUNT:     group_count_reg = cfg_data[4:0];
          CFG_BLOCKS_IN_GROUP: blocks_per_group_reg = cfg_data;
          default: ;
        endcase
      end

      // Item side; group_sel and word_index cannot leave range at these sizes
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          OP_LOAD_WORD:
            bitmap_img[in_data.group_sel][in_data.word_index] = in_data.load_value;
          OP_GROUP_FREE:
            free_img[in_data.group_sel] = (in_data.load_value > 32'(GROUP_FREE_MAX)) ?
                                          GROUP_FREE_MAX : in_data.load_value[FREE_W-1:0];
          OP_TOTAL_FREE:
            total_img = in_data.load_value;
          OP_ALLOCATE:
            grant_queue.push_back(allocate_block());
          default: ;
        endcase
      end
    end
    failures    <= fail_count;
    outstanding <= grant_queue.size();
  end

endmodule

FILE: test/group_bitmap_block_allocator_unit_tb.sv
// group_bitmap_block_allocator_unit_tb: drives loads, allocates and register writes
// into the allocator with random idling and gives the verdict.
// Depends on gbba_pkg, group_bitmap_block_allocator_unit and gbba_alloc_checker.
`timescale 1ns / 1ps

module group_bitmap_block_allocator_unit_tb;
  import gbba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int GAP_MAX     = 13;
  localparam int LONG_HOLD   = 400;
  localparam int NUM_PHASES  = 10;
  localparam int PRESSURE_PH = 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  cfg_ready;
  out_item_t             out_data;
  int                    failures;
  int                    outstanding;

  // Bitmap words already loaded; no scan may touch any other word
  bit loaded [MAX_GROUPS][WORDS_PER_GROUP];
  int scan_words  = 0;
  int sender_calm = 0;
  int hold_reqs   = 0;
  int hold_done   = 0;

  // Settings per random phase: groups, blocks per group, items
  int phase_groups [NUM_PHASES] = '{1, 16, 1, 31, 0, 5, 1, 7, 2, 12};
  int phase_bpg    [NUM_PHASES] = '{8192, 64, 1, 33, 17, 0, 16383, 100, 5000, 31};
  int phase_items  [NUM_PHASES] = '{40, 300, 60, 200, 40, 40, 40, 300, 50, 200};

  group_bitmap_block_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gbba_alloc_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [GROUP_W-1:0] g,
                                         logic [WIDX_W-1:0] w, logic [31:0] v);
    in_item_t it;
    it.opcode     = op;
    it.group_sel  = g;
    it.word_index = w;
    it.load_value = v;
    return it;
  endfunction

  // Bitmap word content: full, nearly full, empty or random
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1:    return 32'hFFFF_FFFF;
      2:       return ~(32'd1 << $urandom_range(0, 31));
      3:       return 32'h0;
      4:       return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Group free count load, including saturation values
  function automatic logic [31:0] rand_free();
    case ($urandom_range(0, 7))
      0, 1:    return 32'd0;
      2, 3:    return $urandom_range(1, 4);
      4:       return 32'd16383;
      5:       return 32'd16384;
      6:       return $urandom;
      default: return $urandom_range(5, 16382);
    endcase
  endfunction

  function automatic logic [31:0] rand_total();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return $urandom_range(1, 3);
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    it = make_item(OP_ALLOCATE, GROUP_W'($urandom_range(0, MAX_GROUPS - 1)),
                   WIDX_W'($urandom_range(0, WORDS_PER_GROUP - 1)), $urandom);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.opcode = OP_ALLOCATE;
    end else if (r < 75) begin
      it.opcode = OP_LOAD_WORD;
      // mostly words the scan can reach
      if (scan_words > 0 && $urandom_range(0, 9) < 7)
        it.word_index = WIDX_W'($urandom_range(0, scan_words - 1));
      it.load_value = rand_word();
    end else if (r < 90) begin
      it.opcode     = OP_GROUP_FREE;
      it.load_value = rand_free();
    end else begin
      it.opcode     = OP_TOTAL_FREE;
      it.load_value = rand_total();
    end
    return it;
  endfunction

  // Offer one item after a random gap and wait until it is taken
  task automatic send_item(in_item_t it);
    int gap;
    if (sender_calm > 0) begin
      sender_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 15) == 0) sender_calm = $urandom_range(10, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.opcode == OP_LOAD_WORD) loaded[it.group_sel][it.word_index] = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain: no result pending, then time for a trailing load
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // New register settings, then load every word a scan could read
  task automatic set_mode(int groups, int bpg);
    int used_groups;
    write_cfg(CFG_GROUP_COUNT, {9'($urandom), 5'(groups)});
    write_cfg(CFG_BLOCKS_IN_GROUP, CFG_DATA_W'(bpg));
    cfg_valid <= 1'b0;
    used_groups = (groups > MAX_GROUPS) ? MAX_GROUPS : groups;
    scan_words  = (bpg == 0) ? 0 :
                  (((bpg > MAX_BLOCKS_PER_GROUP) ? MAX_BLOCKS_PER_GROUP : bpg) + 31) / 32;
    for (int g = 0; g < used_groups; g++) begin
      for (int w = 0; w < scan_words; w++) begin
        if (!loaded[g][w])
          send_item(make_item(OP_LOAD_WORD, GROUP_W'(g), WIDX_W'(w), rand_word()));
      end
    end
  endtask

  // Result side: random stall per item, one long hold-off on request
  initial begin
    int gap;
    int calm;
    calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_reqs != hold_done) begin
        hold_done++;
        gap = LONG_HOLD;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 50);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Run time limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // unused register indexes must leave the settings alone
    write_cfg(CFG_SPARE_2, CFG_DATA_W'($urandom));
    write_cfg(CFG_SPARE_3, CFG_DATA_W'($urandom));

    // Directed: four groups of 40 blocks
    set_mode(4, 40);
    send_item(make_item(OP_TOTAL_FREE, 4'd0, 8'd0, 32'd0));
    send_item(make_item(OP_LOAD_WORD, 4'd0, 8'd0, 32'hFFFF_FFFF));
    // clear bits above the group limit must be ignored
    send_item(make_item(OP_LOAD_WORD, 4'd0, 8'd1, 32'h0000_00FF));
    send_item(make_item(OP_LOAD_WORD, 4'd1, 8'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_LOAD_WORD, 4'd1, 8'd1, 32'hFFFF_FF7F));
    send_item(make_item(OP_LOAD_WORD, 4'd2, 8'd0, 32'h7FFF_FFFF));
    send_item(make_item(OP_LOAD_WORD, 4'd2, 8'd1, 32'h0000_0000));
    send_item(make_item(OP_GROUP_FREE, 4'd0, 8'd0, 32'd5));
    send_item(make_item(OP_GROUP_FREE, 4'd1, 8'd0, 32'd0));
    send_item(make_item(OP_GROUP_FREE, 4'd2, 8'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_GROUP_FREE, 4'd3, 8'd0, 32'd0));
    // full group and empty-count group skipped, total stays at zero
    send_item(make_item(OP_ALLOCATE, 4'd15, 8'd255, 32'hFFFF_FFFF));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    send_item(make_item(OP_TOTAL_FREE, 4'd0, 8'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    // no group left with space
    send_item(make_item(OP_GROUP_FREE, 4'd2, 8'd0, 32'd0));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    // last block of a group, then that group's count runs out
    send_item(make_item(OP_GROUP_FREE, 4'd1, 8'd0, 32'd1));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    send_item(make_item(OP_GROUP_FREE, 4'd3, 8'd0, 32'd16384));
    send_item(make_item(OP_LOAD_WORD, 4'd15, 8'd255, 32'h0000_0000));
    send_item(make_item(OP_TOTAL_FREE, 4'd0, 8'd0, 32'd1));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    send_item(make_item(OP_ALLOCATE, 4'd0, 8'd0, 32'd0));
    wait_idle();

    // Random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_groups[p], phase_bpg[p]);
      if (p == PRESSURE_PH) begin
        hold_reqs++;
        sender_calm = 80;
      end
      repeat (phase_items[p]) send_item(rand_item());
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
